@@ design/m3au_pkg.sv @@
// ----------------------------------------------------------------------------
// Matrix arithmetic unit package
// Operation codes and sequencer states shared by the matrix arithmetic unit.
// ----------------------------------------------------------------------------
package m3au_pkg;

  typedef enum logic [2:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_MUL    = 3'd2,
    OP_SUB    = 3'd3,
    OP_ADD    = 3'd4,
    OP_MUL_T  = 3'd5
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  localparam int unsigned DataWidth = 32;

endpackage

@@ design/matrix_3x3_arith_unit_core.sv @@
// ----------------------------------------------------------------------------
// Matrix arithmetic unit core
// A load item gives no result. A command streams MATRIX_DIM*MATRIX_DIM result
// items, one strobe each. Products accumulate the MATRIX_DIM terms of each
// element one after another, as each matrix memory has a single read port;
// add and subtract compute each element from one read of each matrix.
// Reset clears both matrices at once through per-entry valid bits.
// The receiver cannot stall; busy_o falls in the cycle that carries the last
// result.
// ----------------------------------------------------------------------------
module matrix_3x3_arith_unit_core
  import m3au_pkg::*;
#(
  parameter int unsigned MATRIX_DIM = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [2:0]                  operation_i,
  input  logic [1:0]                  row_index_i,
  input  logic [1:0]                  col_index_i,
  input  logic signed [DataWidth-1:0] load_value_i,
  output logic                        result_valid_o,
  output logic [1:0]                  out_row_o,
  output logic [1:0]                  out_col_o,
  output logic signed [DataWidth-1:0] out_value_o,
  output logic                        last_element_o
);

  localparam int unsigned Cells = MATRIX_DIM * MATRIX_DIM;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned DW    = $clog2(MATRIX_DIM);
  localparam logic [DW-1:0] DimLast = DW'(MATRIX_DIM - 1);

  // Matrix storage and per-entry valid bits.
  logic [DataWidth-1:0] mem_a [Cells];
  logic [DataWidth-1:0] mem_b [Cells];
  logic [Cells-1:0]     a_vld_q, b_vld_q;

  state_e        state_q, state_d;
  op_e           op_q, op_d, op_in;
  logic [DW-1:0] r_q, r_d, c_q, c_d, k_q, k_d;

  logic          accept, issue, is_prod, k_end, cmd_ok, load_ok;
  logic [AW-1:0] a_addr, b_addr, ld_addr;
  logic [DW-1:0] i_idx, j_idx;

  // Read stage registers.
  logic                 s1_vld_q, s1_first_q, s1_lastk_q, s1_lastel_q;
  logic                 s1_mul_q, s1_sub_q;
  logic [DW-1:0]        s1_r_q, s1_c_q;
  logic [DataWidth-1:0] a_rd_q, b_rd_q;
  logic                 a_hit_q, b_hit_q;
  logic [DataWidth-1:0] a_op, b_op, term_d;

  // Term stage registers.
  logic                 s2_vld_q, s2_first_q, s2_lastk_q, s2_lastel_q;
  logic [DW-1:0]        s2_r_q, s2_c_q;
  logic [DataWidth-1:0] term_q, acc_q, acc_d;

  assign op_in   = op_e'(operation_i);
  assign accept  = start_i && !busy_o;
  assign busy_o  = (state_q == ST_RUN) || s1_vld_q || s2_vld_q;
  assign load_ok = (32'(row_index_i) < MATRIX_DIM) && (32'(col_index_i) < MATRIX_DIM);
  assign ld_addr = AW'(32'(row_index_i) * MATRIX_DIM + 32'(col_index_i));

  always_comb begin
    case (op_in)
      OP_MUL, OP_SUB, OP_ADD, OP_MUL_T: cmd_ok = 1'b1;
      default:                          cmd_ok = 1'b0;
    endcase
  end

  // Element addressing: the transposed product swaps row and column.
  assign is_prod = (op_q == OP_MUL) || (op_q == OP_MUL_T);
  assign i_idx   = (op_q == OP_MUL_T) ? c_q : r_q;
  assign j_idx   = (op_q == OP_MUL_T) ? r_q : c_q;
  assign k_end   = !is_prod || (k_q == DimLast);
  assign issue   = (state_q == ST_RUN);

  always_comb begin
    if (is_prod) begin
      a_addr = AW'(32'(i_idx) * MATRIX_DIM + 32'(k_q));
      b_addr = AW'(32'(k_q) * MATRIX_DIM + 32'(j_idx));
    end else begin
      a_addr = AW'(32'(r_q) * MATRIX_DIM + 32'(c_q));
      b_addr = a_addr;
    end
  end

  // Sequencer: walks rows, columns and the inner product index.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && cmd_ok) begin
          state_d = ST_RUN;
          op_d    = op_in;
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
        end
      end
      ST_RUN: begin
        if (!k_end) begin
          k_d = k_q + 1'b1;
        end else begin
          k_d = '0;
          if (c_q != DimLast) begin
            c_d = c_q + 1'b1;
          end else begin
            c_d = '0;
            if (r_q != DimLast) begin
              r_d = r_q + 1'b1;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_MUL;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

  // Memory write on load items, registered read during commands.
  always_ff @(posedge clk_i) begin
    if (accept && load_ok && (op_in == OP_LOAD_A)) begin
      mem_a[ld_addr] <= load_value_i;
    end
    if (accept && load_ok && (op_in == OP_LOAD_B)) begin
      mem_b[ld_addr] <= load_value_i;
    end
    a_rd_q <= mem_a[a_addr];
    b_rd_q <= mem_b[b_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= '0;
      b_vld_q <= '0;
      a_hit_q <= 1'b0;
      b_hit_q <= 1'b0;
    end else begin
      if (accept && load_ok && (op_in == OP_LOAD_A)) begin
        a_vld_q[ld_addr] <= 1'b1;
      end
      if (accept && load_ok && (op_in == OP_LOAD_B)) begin
        b_vld_q[ld_addr] <= 1'b1;
      end
      a_hit_q <= a_vld_q[a_addr];
      b_hit_q <= b_vld_q[b_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q  <= (k_q == '0);
    s1_lastk_q  <= k_end;
    s1_lastel_q <= (r_q == DimLast) && (c_q == DimLast);
    s1_mul_q    <= is_prod;
    s1_sub_q    <= (op_q == OP_SUB);
    s1_r_q      <= r_q;
    s1_c_q      <= c_q;
  end

  // An entry never loaded since reset reads as zero.
  assign a_op = a_hit_q ? a_rd_q : '0;
  assign b_op = b_hit_q ? b_rd_q : '0;

  always_comb begin
    if (s1_mul_q) begin
      term_d = a_op * b_op;
    end else if (s1_sub_q) begin
      term_d = a_op - b_op;
    end else begin
      term_d = a_op + b_op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q      <= term_d;
    s2_first_q  <= s1_first_q;
    s2_lastk_q  <= s1_lastk_q;
    s2_lastel_q <= s1_lastel_q;
    s2_r_q      <= s1_r_q;
    s2_c_q      <= s1_c_q;
  end

  // Accumulate the inner product; emit when the last term arrives.
  assign acc_d = (s2_first_q ? '0 : acc_q) + term_q;

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      acc_q <= acc_d;
    end
    if (s2_vld_q && s2_lastk_q) begin
      out_row_o      <= 2'(s2_r_q);
      out_col_o      <= 2'(s2_c_q);
      out_value_o    <= acc_d;
      last_element_o <= s2_lastel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= s2_vld_q && s2_lastk_q;
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Matrix arithmetic unit testbench
// Loads elements of A and B through the command port and issues multiply,
// subtract, add and transposed-product commands. A table of directed items
// covers the reset state, extreme values, out-of-range loads and unused
// operation codes. A long random run follows. Every result element is checked
// in order against a local model of both matrices.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import m3au_pkg::*;

  localparam int Dim       = 3;
  localparam int Cells     = Dim * Dim;
  localparam int RandItems = 430;
  localparam int NumRows   = 23;

  // Operation codes with no function in the block.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic        last;
  } elem_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] val;
    logic        typed;
    logic [31:0] typed_val;
  } stim_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic [2:0]                  operation_i;
  logic [1:0]                  row_index_i;
  logic [1:0]                  col_index_i;
  logic signed [DataWidth-1:0] load_value_i;
  logic                        result_valid_o;
  logic [1:0]                  out_row_o;
  logic [1:0]                  out_col_o;
  logic signed [DataWidth-1:0] out_value_o;
  logic                        last_element_o;

  logic [31:0] mat_a [Cells];
  logic [31:0] mat_b [Cells];
  elem_t       pending_elems [$];
  int          err_count = 0;

  // Rows with typed set expect typed_val in all nine elements.
  stim_t stim_table [NumRows] = '{
    '{OP_MUL,      2'd0, 2'd0, 32'h0000_0000, 1'b1, 32'h0},
    '{OP_ADD,      2'd0, 2'd0, 32'h0000_0000, 1'b1, 32'h0},
    '{OP_SUB,      2'd1, 2'd2, 32'hFFFF_FFFF, 1'b1, 32'h0},
    '{OP_MUL_T,    2'd3, 2'd3, 32'h8000_0000, 1'b1, 32'h0},
    '{OP_SPARE_LO, 2'd1, 2'd1, 32'h0000_0005, 1'b0, 32'h0},
    '{OP_SPARE_HI, 2'd3, 2'd3, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{OP_LOAD_A,   2'd0, 2'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_LOAD_A,   2'd2, 2'd2, 32'h8000_0000, 1'b0, 32'h0},
    '{OP_LOAD_A,   2'd0, 2'd2, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{OP_LOAD_B,   2'd0, 2'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_LOAD_B,   2'd2, 2'd2, 32'h8000_0000, 1'b0, 32'h0},
    '{OP_LOAD_B,   2'd2, 2'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{OP_LOAD_A,   2'd3, 2'd0, 32'h1234_5678, 1'b0, 32'h0},
    '{OP_LOAD_B,   2'd1, 2'd3, 32'h8765_4321, 1'b0, 32'h0},
    '{OP_LOAD_A,   2'd3, 2'd3, 32'hDEAD_BEEF, 1'b0, 32'h0},
    '{OP_ADD,      2'd0, 2'd0, 32'h0000_0000, 1'b0, 32'h0},
    '{OP_SUB,      2'd0, 2'd0, 32'h0000_0000, 1'b0, 32'h0},
    '{OP_MUL,      2'd2, 2'd1, 32'h0000_0000, 1'b0, 32'h0},
    '{OP_MUL_T,    2'd0, 2'd0, 32'h0000_0000, 1'b0, 32'h0},
    '{OP_LOAD_B,   2'd1, 2'd1, 32'h0000_0001, 1'b0, 32'h0},
    '{OP_LOAD_A,   2'd1, 2'd2, 32'h5555_5555, 1'b0, 32'h0},
    '{OP_LOAD_B,   2'd2, 2'd1, 32'hAAAA_AAAA, 1'b0, 32'h0},
    '{OP_MUL_T,    2'd3, 2'd0, 32'h0000_0000, 1'b0, 32'h0}
  };

  matrix_3x3_arith_unit_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .load_value_i   (load_value_i),
    .result_valid_o (result_valid_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .out_value_o    (out_value_o),
    .last_element_o (last_element_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] row_col_dot(int r, int c);
    logic [31:0] acc;
    acc = '0;
    for (int k = 0; k < Dim; k++) begin
      acc = acc + mat_a[r*Dim+k] * mat_b[k*Dim+c];
    end
    return acc;
  endfunction

  // Updates the matrix copies and queues the nine elements a command yields.
  task automatic apply_item(input stim_t it);
    logic [31:0] v;
    elem_t       e;
    int          idx;
    if (it.op == OP_LOAD_A || it.op == OP_LOAD_B) begin
      if (it.row < Dim && it.col < Dim) begin
        idx = it.row * Dim + it.col;
        if (it.op == OP_LOAD_A) mat_a[idx] = it.val;
        else mat_b[idx] = it.val;
      end
    end else if (it.op >= OP_MUL && it.op <= OP_MUL_T) begin
      for (int r = 0; r < Dim; r++) begin
        for (int c = 0; c < Dim; c++) begin
          idx = r * Dim + c;
          case (it.op)
            OP_MUL:  v = row_col_dot(r, c);
            OP_SUB:  v = mat_a[idx] - mat_b[idx];
            OP_ADD:  v = mat_a[idx] + mat_b[idx];
            default: v = row_col_dot(c, r);
          endcase
          if (it.typed) v = it.typed_val;
          e.row   = r[1:0];
          e.col   = c[1:0];
          e.value = v;
          e.last  = (idx == Cells - 1);
          pending_elems.push_back(e);
        end
      end
    end
  endtask

  // Presents one item, waits for the accepting edge, then maybe idles.
  task automatic issue(input stim_t it, input bit may_idle);
    start_i      <= 1'b1;
    operation_i  <= it.op;
    row_index_i  <= it.row;
    col_index_i  <= it.col;
    load_value_i <= it.val;
    do @(posedge clk_i); while (busy_o);
    apply_item(it);
    if (may_idle && $urandom_range(0, 99) < 28) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic quiesce();
    start_i <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    elem_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_elems.size() == 0) begin
        $display("%0t: unexpected element row %0d col %0d value %h last %b", $time,
                 out_row_o, out_col_o, out_value_o, last_element_o);
        err_count++;
      end else begin
        want = pending_elems.pop_front();
        if ({out_row_o, out_col_o, out_value_o, last_element_o} !== want) begin
          $display("%0t: expected row %0d col %0d value %h last %b, got %0d %0d %h %b",
                   $time, want.row, want.col, want.value, want.last,
                   out_row_o, out_col_o, out_value_o, last_element_o);
          err_count++;
        end
      end
    end
  end

  initial begin
    stim_t it;
    int    kind;
    int    counted;
    int    n;
    for (int i = 0; i < Cells; i++) begin
      mat_a[i] = '0;
      mat_b[i] = '0;
    end
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    operation_i  <= OP_LOAD_A;
    row_index_i  <= '0;
    col_index_i  <= '0;
    load_value_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) issue(stim_table[i], 1'b1);
    quiesce();

    counted = 0;
    n = 0;
    while (counted < RandItems) begin
      kind         = $urandom_range(0, 99);
      it.typed     = 1'b0;
      it.typed_val = '0;
      it.val       = rand_value();
      it.row       = 2'($urandom_range(0, 2));
      it.col       = 2'($urandom_range(0, 2));
      if (kind < 60) begin
        it.op = $urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A;
      end else if (kind < 85) begin
        it.row = 2'($urandom_range(0, 3));
        it.col = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0:       it.op = OP_MUL;
          1:       it.op = OP_SUB;
          2:       it.op = OP_ADD;
          default: it.op = OP_MUL_T;
        endcase
      end else if (kind < 95) begin
        // Load with at least one index past the matrix edge.
        it.op = $urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A;
        it.row = 2'($urandom_range(0, 3));
        it.col = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) it.row = 2'd3;
        else it.col = 2'd3;
      end else begin
        it.op  = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        it.row = 2'($urandom_range(0, 3));
        it.col = 2'($urandom_range(0, 3));
      end
      if (n == 120 || n == 400) quiesce();
      // Items 200 to 299 of the random part run with no idle cycles.
      issue(it, !(counted >= 200 && counted < 300));
      counted++;
      n++;
    end

    quiesce();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/m3au_pkg.sv
design/matrix_3x3_arith_unit_core.sv
tb/tb.sv
